/* sv/nsc_pkg.sv */
`timescale 1ns / 1ps

package nsc_pkg;

   // one character word of a sentence
   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_sentence;
   } req_type;

   // one verdict word per sentence
   typedef struct packed {
      logic       sentence_ok;
      logic [2:0] error_code;
      logic [7:0] computed_checksum;
   } rsp_type;

   // error codes reported in error_code
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NO_DOLLAR = 3'd1;
   localparam logic [2:0] ERR_BAD_HEX   = 3'd2;
   localparam logic [2:0] ERR_MISMATCH  = 3'd3;
   localparam logic [2:0] ERR_MISSING   = 3'd4;
   localparam logic [2:0] ERR_TERM      = 3'd5;

endpackage

/* sv/nsc_parse.sv */
`timescale 1ns / 1ps

module nsc_parse (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  nsc_pkg::req_type item,
   input  logic             require_checksum,
   output nsc_pkg::rsp_type result
);

   typedef enum logic [2:0] {
      PH_START,
      PH_BODY,
      PH_HEX1,
      PH_HEX2,
      PH_AFTER,
      PH_CR,
      PH_LF,
      PH_FAIL
   } phase_type;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   phase_type  phase_ff, phase_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] expected_ff, expected_in;
   logic [2:0] error_ff, error_in;
   logic [2:0] final_error;
   logic       hex_valid;
   logic [3:0] hex_nibble;
   logic [7:0] expected_full;

   // hex digit decode, upper and lower case
   always_comb begin
      hex_valid  = 1'b1;
      hex_nibble = 4'd0;
      if (item.char_byte >= 8'h30 && item.char_byte <= 8'h39) begin
         hex_nibble = item.char_byte[3:0];
      end else if ((item.char_byte >= 8'h41 && item.char_byte <= 8'h46) ||
                   (item.char_byte >= 8'h61 && item.char_byte <= 8'h66)) begin
         hex_nibble = item.char_byte[3:0] + 4'd9;
      end else begin
         hex_valid = 1'b0;
      end
   end

   assign expected_full = {expected_ff[7:4], hex_nibble};

   // per-character phase update, first error sticks
   always_comb begin
      phase_in    = phase_ff;
      xor_in      = xor_ff;
      expected_in = expected_ff;
      error_in    = error_ff;
      unique case (phase_ff)
         PH_START: begin
            if (item.char_byte == CHAR_DOLLAR) begin
               phase_in = PH_BODY;
            end else begin
               phase_in = PH_FAIL;
               error_in = nsc_pkg::ERR_NO_DOLLAR;
            end
         end
         PH_BODY: begin
            if (item.char_byte == CHAR_STAR) begin
               phase_in = PH_HEX1;
            end else begin
               xor_in = xor_ff ^ item.char_byte;
            end
         end
         PH_HEX1: begin
            if (!hex_valid) begin
               phase_in = PH_FAIL;
               error_in = nsc_pkg::ERR_BAD_HEX;
            end else begin
               expected_in = {hex_nibble, 4'd0};
               phase_in    = PH_HEX2;
            end
         end
         PH_HEX2: begin
            if (!hex_valid) begin
               phase_in = PH_FAIL;
               error_in = nsc_pkg::ERR_BAD_HEX;
            end else begin
               expected_in = expected_full;
               if (expected_full == 8'd0 || expected_full != xor_ff) begin
                  phase_in = PH_FAIL;
                  error_in = nsc_pkg::ERR_MISMATCH;
               end else begin
                  phase_in = PH_AFTER;
               end
            end
         end
         PH_AFTER: begin
            if (item.char_byte == CHAR_LF) begin
               phase_in = PH_LF;
            end else if (item.char_byte == CHAR_CR) begin
               phase_in = PH_CR;
            end else begin
               phase_in = PH_FAIL;
               error_in = nsc_pkg::ERR_TERM;
            end
         end
         PH_CR: begin
            if (item.char_byte == CHAR_LF) begin
               phase_in = PH_LF;
            end else begin
               phase_in = PH_FAIL;
               error_in = nsc_pkg::ERR_TERM;
            end
         end
         PH_LF: begin
            phase_in = PH_FAIL;
            error_in = nsc_pkg::ERR_TERM;
         end
         PH_FAIL: begin
         end
         default: begin
         end
      endcase
   end

   // end-of-sentence checks on the phase left by the final character
   always_comb begin
      final_error = error_in;
      case (phase_in)
         PH_BODY: begin
            if (require_checksum) begin
               final_error = nsc_pkg::ERR_MISSING;
            end
         end
         PH_HEX1, PH_HEX2: final_error = nsc_pkg::ERR_BAD_HEX;
         PH_CR:            final_error = nsc_pkg::ERR_TERM;
         PH_START:         final_error = nsc_pkg::ERR_NO_DOLLAR;
         default:          final_error = error_in;
      endcase
   end

   assign result.sentence_ok       = (final_error == nsc_pkg::ERR_NONE);
   assign result.error_code        = final_error;
   assign result.computed_checksum = xor_in;

   // sentence state, cleared after each final character
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         xor_ff      <= 8'd0;
         expected_ff <= 8'd0;
         error_ff    <= nsc_pkg::ERR_NONE;
      end else if (advance) begin
         if (item.end_of_sentence) begin
            phase_ff    <= PH_START;
            xor_ff      <= 8'd0;
            expected_ff <= 8'd0;
            error_ff    <= nsc_pkg::ERR_NONE;
         end else begin
            phase_ff    <= phase_in;
            xor_ff      <= xor_in;
            expected_ff <= expected_in;
            error_ff    <= error_in;
         end
      end
   end

endmodule

/* sv/nmea_sentence_checker.sv */
`timescale 1ns / 1ps

// NMEA 0183 sentence checker. Characters enter one word per cycle on the req
// channel; the word flagged end_of_sentence yields one verdict word on the rsp
// channel, with rsp_valid rising once that word has passed the input register
// and then the verdict register, carrying pass/fail, the first error found and
// the XOR checksum of the characters between '$' and '*' (or the end). Every
// character is handled combinationally by the parser between the input register
// and the verdict register, so the block sustains one character per cycle; it
// only holds back req_ready while a finished verdict is waiting on rsp_ready
// and another final character is due. require_checksum is set via the csr
// channel, which is always ready, and should be written between sentences.
module nmea_sentence_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nsc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   logic             in_valid_ff;
   nsc_pkg::req_type in_word_ff;
   logic             out_valid_ff;
   nsc_pkg::rsp_type out_word_ff;
   logic             require_ff;
   logic             advance;
   nsc_pkg::rsp_type result;

   // a character moves on unless its verdict would land on a stalled one
   assign advance   = in_valid_ff &&
                      (!in_word_ff.end_of_sentence || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         require_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         require_ff <= csr_data;
      end
   end

   // input word register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
   end

   nsc_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .item             (in_word_ff),
      .require_checksum (require_ff),
      .result           (result)
   );

   // verdict register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_word_ff.end_of_sentence) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && in_word_ff.end_of_sentence) begin
         out_word_ff <= result;
      end
   end

   // a new verdict only follows a final character moving on
   a_verdict_source: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !$past(out_valid_ff)) |->
         $past(in_valid_ff && in_word_ff.end_of_sentence))
      else $error("verdict without a final character");

   // a stalled verdict is never overwritten
   a_verdict_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(out_word_ff)))
      else $error("stalled verdict lost");

   // pass flag agrees with the error code
   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |->
         (out_word_ff.sentence_ok == (out_word_ff.error_code == nsc_pkg::ERR_NONE)))
      else $error("pass flag and error code disagree");

   // only defined error codes leave the block
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_word_ff.error_code <= nsc_pkg::ERR_TERM))
      else $error("undefined error code");

endmodule
